>>> design/utf16_to_utf8_transcoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define UTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/utt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, queue entry type, byte phase enum and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package utt_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int          CFG_INDEX_W      = 2;
	localparam logic [1:0]  REG_BE_DEFAULT   = 2'd0;
	localparam logic [1:0]  REG_OUT_CAPACITY = 2'd1;
	localparam logic [15:0] CAPACITY_RESET   = 16'd256;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
	localparam logic [20:0] SUPP_BASE  = 21'h010000;
	localparam logic [7:0]  BOM_FE     = 8'hFE;
	localparam logic [7:0]  BOM_FF     = 8'hFF;

	// where we are within the current code unit
	typedef enum logic [1:0] {
		PH_FIRST_A,
		PH_FIRST_B,
		PH_NEXT_A,
		PH_NEXT_B
	} utt_phase_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} utt_enc_t;

	// one queue entry: all output beats caused by one input byte
	typedef struct packed {
		logic [5:0][7:0] data;
		logic [2:0]      n_bytes;
		logic            is_end;
		logic            trunc;
		logic [15:0]     base_len;
	} utt_entry_t;

	function automatic utt_enc_t utt_encode(input logic [20:0] cp);
		utt_enc_t e;
		e.bytes = '0;
		e.len   = 3'd1;
		priority if (cp < 21'h000080) begin
			e.len      = 3'd1;
			e.bytes[0] = cp[7:0];
		end else if (cp < 21'h000800) begin
			e.len      = 3'd2;
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h010000) begin
			e.len      = 3'd3;
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			e.len      = 3'd4;
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

>>> design/utt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder queue
// Small FIFO of decoded entries between the front and the serializer.
// ----------------------------------------------------------------------------
module utt_queue #(
	parameter int DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utt_pkg::utt_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                nonempty,
	output utt_pkg::utt_entry_t head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utt_pkg::utt_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> design/utt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder front end
// Pairs bytes into units, handles byte-order mark and surrogates, checks room
// and encodes up to two code points per input beat into one queue entry.
// ----------------------------------------------------------------------------
module utt_front #(
	parameter int COUNT_BITS = utt_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          src_byte,
	input  logic                last_byte,
	input  logic                be_default,
	input  logic [15:0]         capacity,
	input  logic                q_full,
	output logic                push,
	output utt_pkg::utt_entry_t push_entry
);
	localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	utt_pkg::utt_phase_t phase_q, phase_d;
	logic [7:0]            held_q;
	logic                  use_be_q;
	logic [9:0]            pend_hi_q;
	logic                  pend_q;
	logic [COUNT_BITS-1:0] wc_q;
	logic                  halted_q, stopped_q;

	logic              accept, active, is_bom, do_unit;
	logic [15:0]       unit;
	logic              is_low, is_high, is_zero;
	logic [20:0]       pair_cp, cp1, cp2;
	utt_pkg::utt_enc_t enc1, enc2;
	logic [SUM_W-1:0]  wc_ext, s1, base2, s2;
	logic              slot1, fits1, halt1, normal, pend_mid, stop_new;
	logic              e_norm, e_tail, slot2, fits2, halt2, w1, w2, halt_new;
	logic [COUNT_BITS-1:0] wc_new;

	assign accept = in_valid && !q_full;
	assign active = !halted_q && !stopped_q;

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (last_byte) begin
				phase_d = utt_pkg::PH_FIRST_A;
			end else if (active) begin
				unique case (phase_q)
					utt_pkg::PH_FIRST_A: phase_d = utt_pkg::PH_FIRST_B;
					utt_pkg::PH_FIRST_B: phase_d = utt_pkg::PH_NEXT_A;
					utt_pkg::PH_NEXT_A:  phase_d = utt_pkg::PH_NEXT_B;
					utt_pkg::PH_NEXT_B:  phase_d = utt_pkg::PH_NEXT_A;
				endcase
			end
		end
	end

	always_comb begin
		unit    = use_be_q ? {held_q, src_byte} : {src_byte, held_q};
		is_bom  = (phase_q == utt_pkg::PH_FIRST_B) &&
			(((held_q == utt_pkg::BOM_FF) && (src_byte == utt_pkg::BOM_FE)) ||
			 ((held_q == utt_pkg::BOM_FE) && (src_byte == utt_pkg::BOM_FF)));
		do_unit = active && (((phase_q == utt_pkg::PH_FIRST_B) && !is_bom) ||
			(phase_q == utt_pkg::PH_NEXT_B));
		is_low  = (unit >= utt_pkg::LOW_FIRST) && (unit <= utt_pkg::LOW_LAST);
		is_high = (unit >= utt_pkg::HIGH_FIRST) && (unit <= utt_pkg::HIGH_LAST);
		is_zero = (unit == 16'd0);

		// first slot: whatever the held high surrogate turns into
		pair_cp = utt_pkg::SUPP_BASE + 21'({pend_hi_q, unit[9:0]});
		slot1   = do_unit && pend_q;
		cp1     = is_low ? pair_cp : utt_pkg::REPL_CHAR;
		enc1    = utt_pkg::utt_encode(cp1);
		wc_ext  = SUM_W'(wc_q);
		s1      = wc_ext + SUM_W'(enc1.len);
		fits1   = (s1 < SUM_W'(capacity)) && (s1[SUM_W-1:COUNT_BITS] == '0);
		halt1   = slot1 && !fits1;

		normal   = do_unit && !(pend_q && is_low) && !halt1;
		pend_mid = do_unit ? (normal && is_high) : pend_q;
		stop_new = stopped_q || (normal && is_zero);

		// second slot: the unit itself, or a high surrogate left at string end
		e_norm = normal && !is_zero && !is_high;
		e_tail = last_byte && pend_mid && !halted_q && !halt1 && !stop_new;
		slot2  = e_norm || e_tail;
		cp2    = (e_norm && !is_low) ? 21'(unit) : utt_pkg::REPL_CHAR;
		enc2   = utt_pkg::utt_encode(cp2);
		base2  = slot1 ? s1 : wc_ext;
		s2     = base2 + SUM_W'(enc2.len);
		fits2  = (s2 < SUM_W'(capacity)) && (s2[SUM_W-1:COUNT_BITS] == '0);
		halt2  = slot2 && !fits2;

		w1       = slot1 && fits1;
		w2       = slot2 && fits2;
		halt_new = halted_q || halt1 || halt2;
		wc_new   = w2 ? s2[COUNT_BITS-1:0] : (w1 ? s1[COUNT_BITS-1:0] : wc_q);

		push_entry.data = '0;
		for (int k = 0; k < 4; k++) begin
			if (w1) begin
				push_entry.data[k] = enc1.bytes[k];
			end
		end
		// a second code point only ever follows a three-byte replacement
		for (int k = 0; k < 3; k++) begin
			if (w2) begin
				if (w1) begin
					push_entry.data[k + 3] = enc2.bytes[k];
				end else begin
					push_entry.data[k] = enc2.bytes[k];
				end
			end
		end
		push_entry.n_bytes  = (w1 ? enc1.len : 3'd0) + (w2 ? enc2.len : 3'd0);
		push_entry.is_end   = last_byte;
		push_entry.trunc    = halt_new;
		push_entry.base_len = wc_ext[15:0];

		push = accept && (last_byte || w1 || w2);
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			if (phase_q == utt_pkg::PH_FIRST_A || phase_q == utt_pkg::PH_NEXT_A) begin
				held_q <= src_byte;
			end
			if (phase_q == utt_pkg::PH_FIRST_A) begin
				use_be_q <= be_default;
			end else if (is_bom) begin
				use_be_q <= (held_q == utt_pkg::BOM_FE);
			end
			if (normal && is_high) begin
				pend_hi_q <= unit[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= utt_pkg::PH_FIRST_A;
			pend_q    <= 1'b0;
			wc_q      <= '0;
			halted_q  <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				if (last_byte) begin
					pend_q    <= 1'b0;
					wc_q      <= '0;
					halted_q  <= 1'b0;
					stopped_q <= 1'b0;
				end else begin
					pend_q    <= pend_mid;
					wc_q      <= wc_new;
					halted_q  <= halt_new;
					stopped_q <= stop_new;
				end
			end
		end
	end

endmodule

>>> design/utt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder serializer
// Walks the head one beat per unstalled cycle into a registered output stage.
// ----------------------------------------------------------------------------
module utt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_nonempty,
	input  utt_pkg::utt_entry_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                end_of_string,
	output logic [15:0]         out_length,
	output logic                truncated
);
	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        bvalid_q, eos_q, trunc_q;
	logic [15:0] len_q;

	logic is_data, last_item, load;

	assign is_data   = (idx_q < q_head.n_bytes);
	assign last_item = q_head.is_end ? (idx_q == q_head.n_bytes)
		: (idx_q == q_head.n_bytes - 3'd1);
	// output stage refills when empty or as its beat leaves
	assign load  = q_nonempty && (!out_valid_q || !out_stall);
	assign q_pop = load && last_item;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= is_data ? q_head.data[idx_q] : 8'd0;
			bvalid_q <= is_data;
			eos_q    <= !is_data;
			len_q    <= q_head.base_len + 16'(idx_q) + (is_data ? 16'd1 : 16'd0);
			trunc_q  <= !is_data && q_head.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign byte_valid    = bvalid_q;
	assign end_of_string = eos_q;
	assign out_length    = len_q;
	assign truncated     = trunc_q;

endmodule

>>> design/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Takes a UTF-16 string one byte per beat and returns its UTF-8 bytes, then
// one end beat that carries the final length and the truncation flag. Input
// bytes are taken one per cycle as long as the entry queue (QUEUE_DEPTH
// entries, one per input byte that yields output) has room; the front decodes
// and encodes a byte in the cycle it arrives. The serializer behind the queue
// sends one output beat per cycle while out_stall is low. One input byte
// yields up to six UTF-8 bytes, where a stray high surrogate is followed by a
// three-byte unit; input bytes that yield nothing add no output beats. The
// first output passes through the queue and the registered output stage.
// No clearing pass after reset. Configuration writes are taken at any time,
// one per cycle.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module utf16_to_utf8_transcoder #(
	parameter int COUNT_BITS  = utt_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [utt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      src_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_byte,
	output logic                            byte_valid,
	output logic                            end_of_string,
	output logic [15:0]                     out_length,
	output logic                            truncated
);
	logic                be_default_q;
	logic [15:0]         capacity_q;
	logic                q_full, q_nonempty, q_push, q_pop;
	utt_pkg::utt_entry_t push_entry, q_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			be_default_q <= 1'b0;
			capacity_q   <= utt_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				utt_pkg::REG_BE_DEFAULT:   be_default_q <= cfg_data[0];
				utt_pkg::REG_OUT_CAPACITY: capacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	utt_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.src_byte   (src_byte),
		.last_byte  (last_byte),
		.be_default (be_default_q),
		.capacity   (capacity_q),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (push_entry)
	);

	utt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	utt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nonempty    (q_nonempty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.out_length    (out_length),
		.truncated     (truncated)
	);

	// data beats are only sent while the string still has room
	`UTT_ASSERT_NOW(a_data_not_trunc, clk, arst_n,
		out_valid && byte_valid, !truncated, "data beat flagged truncated")

	// after a data beat the length steps by one, or holds on the end beat
	`UTT_ASSERT_NEXT(a_len_step, clk, arst_n,
		out_valid && !out_stall && byte_valid,
		!out_valid || (byte_valid ? (out_length == $past(out_length) + 16'd1)
			: (out_length == $past(out_length))),
		"output length out of step")

	// a new string restarts the count
	`UTT_ASSERT_NEXT(a_len_restart, clk, arst_n,
		out_valid && !out_stall && end_of_string,
		!out_valid || !byte_valid || (out_length == 16'd1),
		"length not restarted after end beat")

endmodule
